// ===== rtl/core/sha256h_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha256h_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned LEN_POS     = 56;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Commands to the compression unit.
  typedef struct packed {
    logic start;    // load working variables from the chain value
    logic round;    // run one round
    logic fold;     // add working variables into the chain value
    logic restart;  // return the chain value to its initial value
  } core_ctrl_t;

  // Commands to the block window / message schedule.
  typedef struct packed {
    logic       shift_byte;
    logic       step;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/core/sha256h_sched.sv =====
// Block window: byte loading shift line that doubles as the message schedule.
module sha256h_sched (
  input  logic                       clk,
  input  sha256h_pkg::sched_ctrl_t   ctrl,
  output logic [31:0]                w
);

  // Word j of the window sits at bits [511-32j -: 32]; word 0 is the oldest.
  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  w_new;

  assign w = win_r[511:480];

  assign w_new = win_r[511:480]
               + sha256h_pkg::small_sigma0(win_r[479:448])
               + win_r[223:192]
               + sha256h_pkg::small_sigma1(win_r[63:32]);

  always_comb begin
    win_nxt = win_r;
    if (ctrl.shift_byte) begin
      win_nxt = {win_r[503:0], ctrl.byte_val};
    end else if (ctrl.step) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

// ===== rtl/core/sha256h_core.sv =====
// Compression unit: one SHA-256 round per cycle plus the chain value registers.
module sha256h_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sha256h_pkg::core_ctrl_t   ctrl,
  input  logic [31:0]               w,
  output logic                      last_round,
  output logic [255:0]              chain
);

  localparam logic [5:0] LAST_RND = 6'(sha256h_pkg::ROUNDS - 1);

  logic [31:0] h_r   [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r   [8];
  logic [31:0] v_nxt [8];
  logic [5:0]  rnd_r;
  logic [5:0]  rnd_nxt;
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v_r[7] + sha256h_pkg::big_sigma1(v_r[4])
            + sha256h_pkg::choose(v_r[4], v_r[5], v_r[6])
            + sha256h_pkg::round_k(rnd_r) + w;
  assign t2 = sha256h_pkg::big_sigma0(v_r[0]) + sha256h_pkg::majority(v_r[0], v_r[1], v_r[2]);

  assign last_round = (rnd_r == LAST_RND);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain[255 - 32*i -: 32] = h_r[i];
    end
  end

  always_comb begin
    h_nxt   = h_r;
    v_nxt   = v_r;
    rnd_nxt = rnd_r;
    if (ctrl.start) begin
      v_nxt   = h_r;
      rnd_nxt = '0;
    end else if (ctrl.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
      rnd_nxt  = rnd_r + 6'd1;
    end
    if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end else if (ctrl.restart) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = sha256h_pkg::H_INIT[255 - 32*i -: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha256h_pkg::H_INIT[255 - 32*i -: 32];
      end
      rnd_r <= '0;
    end else begin
      h_r   <= h_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: sequencer, counters and result register.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------------------
//   in_     | input     | in_valid/in_ready   | data_byte[8], has_byte, end_of_message
//   out_    | output    | out_valid/out_ready | digest_part_0..3, 64 bits each
//
// An item without an end mark whose byte does not complete a block leaves the sequencer idle.
// A byte that completes the 64-byte block adds one compression: 64 rounds in the shared
// round unit, then a fold into the chain value.
// An end mark adds padding bytes shifted in one per cycle up to the end of the block
// (at most 64 in one block, at most 72 when the padding spills into a second block), one
// or two compressions, and a load of the result into the output register.
// Reset clears the sequencer, the counters and the result valid flag; there is no
// clearing pass. in_ready is low while an item is being worked on; a finished digest
// waits in the output register, and the block stalls only if a second digest is ready
// before the first transfer has completed.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_part_0,
  output logic [63:0] out_digest_part_1,
  output logic [63:0] out_digest_part_2,
  output logic [63:0] out_digest_part_3
);

  localparam logic [5:0] LAST_POS = 6'(sha256h_pkg::BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_POS  = 6'(sha256h_pkg::LEN_POS);
  localparam logic [63:0] BLOCK_BITS = 64'(sha256h_pkg::BLOCK_BYTES * 8);

  sha256h_pkg::state_t      state_r, state_nxt;
  sha256h_pkg::core_ctrl_t  core_ctrl;
  sha256h_pkg::sched_ctrl_t sched_ctrl;

  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [63:0]  total_r, total_nxt;
  logic         eom_r, eom_nxt;        // end mark waiting behind a full-block compression
  logic         pad_mode_r, pad_mode_nxt;  // current compression is a padding block
  logic         first_r, first_nxt;    // next padding byte is the 0x80 marker
  logic         len_ok_r, len_ok_nxt;  // this padding block carries the length field
  logic         out_valid_r, out_valid_nxt;
  logic [255:0] digest_r, digest_nxt;

  logic         in_xfer;
  logic         last_round;
  logic [255:0] chain;
  logic [31:0]  w;
  logic [5:0]   fill_inc;
  logic [5:0]   len_shift;
  logic [7:0]   len_byte;
  logic [7:0]   pad_val;
  logic         emit_load;

  assign in_ready  = (state_r == sha256h_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign fill_inc  = fill_r + 6'd1;
  assign emit_load = (state_r == sha256h_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_shift = {~fill_r[2:0], 3'b000};
  assign len_byte  = 8'(total_r >> len_shift);
  assign pad_val   = first_r ? sha256h_pkg::PAD_BYTE
                   : ((len_ok_r && (fill_r >= LEN_POS)) ? len_byte : 8'h00);

  sha256h_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w    (w)
  );

  sha256h_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (core_ctrl),
    .w          (w),
    .last_round (last_round),
    .chain      (chain)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256h_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_has_byte && (fill_r == LAST_POS)) begin
            state_nxt = sha256h_pkg::ST_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = sha256h_pkg::ST_PAD;
          end
        end
      end
      sha256h_pkg::ST_ROUND: begin
        if (last_round) begin
          state_nxt = sha256h_pkg::ST_FOLD;
        end
      end
      sha256h_pkg::ST_FOLD: begin
        if (pad_mode_r) begin
          state_nxt = len_ok_r ? sha256h_pkg::ST_EMIT : sha256h_pkg::ST_PAD;
        end else begin
          state_nxt = eom_r ? sha256h_pkg::ST_PAD : sha256h_pkg::ST_IDLE;
        end
      end
      sha256h_pkg::ST_PAD: begin
        if (fill_r == LAST_POS) begin
          state_nxt = sha256h_pkg::ST_ROUND;
        end
      end
      sha256h_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_nxt = sha256h_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256h_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and counter updates.
  always_comb begin
    core_ctrl     = '0;
    sched_ctrl    = '0;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    total_nxt     = total_r;
    eom_nxt       = eom_r;
    pad_mode_nxt  = pad_mode_r;
    first_nxt     = first_r;
    len_ok_nxt    = len_ok_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      sha256h_pkg::ST_IDLE: begin
        if (in_xfer) begin
          eom_nxt      = in_end_of_message;
          pad_mode_nxt = 1'b0;
          first_nxt    = 1'b1;
          if (in_has_byte) begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.byte_val   = in_data_byte;
            fill_nxt              = fill_inc;
            core_ctrl.start       = (fill_r == LAST_POS);
          end
          total_nxt  = bits_r + {55'd0, fill_nxt, 3'b000};
          len_ok_nxt = (fill_nxt < LEN_POS);
        end
      end
      sha256h_pkg::ST_ROUND: begin
        core_ctrl.round = 1'b1;
        sched_ctrl.step = 1'b1;
      end
      sha256h_pkg::ST_FOLD: begin
        core_ctrl.fold = 1'b1;
        if (pad_mode_r) begin
          len_ok_nxt = 1'b1;
        end else begin
          bits_nxt   = bits_r + BLOCK_BITS;
          total_nxt  = bits_r + BLOCK_BITS;
          len_ok_nxt = 1'b1;
          first_nxt  = 1'b1;
        end
      end
      sha256h_pkg::ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_val   = pad_val;
        fill_nxt              = fill_inc;
        first_nxt             = 1'b0;
        if (fill_r == LAST_POS) begin
          core_ctrl.start = 1'b1;
          pad_mode_nxt    = 1'b1;
        end
      end
      sha256h_pkg::ST_EMIT: begin
        if (emit_load) begin
          digest_nxt        = chain;
          out_valid_nxt     = 1'b1;
          core_ctrl.restart = 1'b1;
          bits_nxt          = '0;
          fill_nxt          = '0;
        end
      end
      default: begin
        fill_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256h_pkg::ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      eom_r       <= 1'b0;
      pad_mode_r  <= 1'b0;
      first_r     <= 1'b1;
      len_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      eom_r       <= eom_nxt;
      pad_mode_r  <= pad_mode_nxt;
      first_r     <= first_nxt;
      len_ok_r    <= len_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r  <= total_nxt;
    digest_r <= digest_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_digest_part_0 = digest_r[255:192];
  assign out_digest_part_1 = digest_r[191:128];
  assign out_digest_part_2 = digest_r[127:64];
  assign out_digest_part_3 = digest_r[63:0];

  // After the last round the fold cycle always follows.
  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256h_pkg::ST_ROUND && last_round) |=> (state_r == sha256h_pkg::ST_FOLD))
    else $error("fold did not follow the last round");

  // A new digest appears only out of the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == sha256h_pkg::ST_EMIT))
    else $error("digest loaded outside the emit state");

  // Emitting a digest restarts the message counters.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> (fill_r == 6'd0 && bits_r == 64'd0))
    else $error("counters not cleared after digest");

  // Padding compressions do not count toward the message length.
  a_pad_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256h_pkg::ST_FOLD && pad_mode_r) |=> $stable(bits_r))
    else $error("bit count changed by a padding block");

  // The block buffer is empty after every full-block fold.
  a_pad_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha256h_pkg::ST_FOLD && !pad_mode_r) |=> (fill_r == 6'd0))
    else $error("fill count not cleared after a full block");

endmodule
